// ----- src/modexp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the modular exponentiation core.
// No dependencies; imported by the top level.
package modexp_pkg;

	// Width of the message, key and result fields.
	localparam int FIELD_W = 32;

	// Configuration port geometry: two 32-bit registers at byte addresses 0 and 4.
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	typedef logic [0:0] reg_idx_t;
	localparam reg_idx_t REG_EXPONENT = 1'b0;
	localparam reg_idx_t REG_MODULUS  = 1'b1;

	// Exponentiation sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_MUL,
		ST_SQR,
		ST_WAIT
	} modexp_state_t;

endpackage

// ----- src/modular_exponentiation_core.sv -----
`timescale 1ns / 1ps
// Modular exponentiation core: power_mod = message ^ exponent mod modulus.
// The message reduction and every multiply and squaring run on the bit-serial multiplier,
// one multiplier bit per cycle; a zero exponent or a modulus <= 1 skips the multiplier.
// One transaction is in work at a time; the next is taken once the result sits in the output register.
// Reset: exponent and modulus registers return to 1, sequencer idle, no result pending.
module modular_exponentiation_core
	import modexp_pkg::*;
#(
	parameter int WORD_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	// Configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	// Message channel
	input  logic               message_valid,
	output logic               message_stall,
	input  logic [FIELD_W-1:0] message,
	// Result channel
	output logic               power_mod_valid,
	input  logic               power_mod_stall,
	output logic [FIELD_W-1:0] power_mod
);

	logic [FIELD_W-1:0]   exponent_q;
	logic [FIELD_W-1:0]   modulus_q;

	modexp_state_t        state_q;
	modexp_state_t        state_d;

	logic [WORD_BITS-1:0] acc_q;
	logic [WORD_BITS-1:0] acc_d;
	logic [WORD_BITS-1:0] base_q;
	logic [WORD_BITS-1:0] base_d;
	logic [WORD_BITS-1:0] e_q;
	logic [WORD_BITS-1:0] e_d;

	logic [WORD_BITS-1:0] msg_w;
	logic [WORD_BITS-1:0] exp_w;
	logic [WORD_BITS-1:0] mod_w;
	logic [WORD_BITS-1:0] e_rest;

	logic                 mm_start;
	logic [WORD_BITS-1:0] mm_a;
	logic [WORD_BITS-1:0] mm_b;
	logic                 mm_done;
	logic [WORD_BITS-1:0] mm_product;

	logic                 power_mod_valid_q;
	logic [FIELD_W-1:0]   power_mod_q;
	logic                 out_load;
	logic                 msg_accept;
	logic                 cfg_write;

	// Key registers
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exponent_q <= FIELD_W'(1);
			modulus_q  <= FIELD_W'(1);
		end else if (cfg_write) begin
			case (reg_idx_t'(paddr[2]))
				REG_EXPONENT: exponent_q <= pwdata;
				REG_MODULUS:  modulus_q  <= pwdata;
				default:      ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[2]))
			REG_EXPONENT: prdata = exponent_q;
			REG_MODULUS:  prdata = modulus_q;
			default:      prdata = '0;
		endcase
	end

	// Operands at the datapath width
	assign msg_w  = WORD_BITS'(message);
	assign exp_w  = WORD_BITS'(exponent_q);
	assign mod_w  = WORD_BITS'(modulus_q);
	assign e_rest = {1'b0, e_q[WORD_BITS-1:1]};

	assign message_stall = (state_q != ST_IDLE);
	assign msg_accept    = message_valid && !message_stall;
	assign out_load      = (state_q == ST_WAIT) && (!power_mod_valid_q || !power_mod_stall);

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Right-to-left square-and-multiply: reduce the message, then per exponent bit
	// multiply into the accumulator if set and square the base; stop after the top set bit.
	always_comb begin
		state_d  = state_q;
		acc_d    = acc_q;
		base_d   = base_q;
		e_d      = e_q;
		mm_start = 1'b0;
		mm_a     = mm_product;
		mm_b     = mm_product;
		case (state_q)
			ST_IDLE: begin
				if (msg_accept) begin
					e_d = exp_w;
					if (exp_w == '0) begin
						acc_d   = WORD_BITS'(1);
						state_d = ST_WAIT;
					end else if (mod_w <= WORD_BITS'(1)) begin
						acc_d   = '0;
						state_d = ST_WAIT;
					end else begin
						mm_start = 1'b1;
						mm_a     = WORD_BITS'(1);
						mm_b     = msg_w;
						state_d  = ST_REDUCE;
					end
				end
			end
			ST_REDUCE: begin
				if (mm_done) begin
					base_d   = mm_product;
					acc_d    = WORD_BITS'(1);
					mm_start = 1'b1;
					if (e_q[0]) begin
						mm_a    = WORD_BITS'(1);
						state_d = ST_MUL;
					end else begin
						state_d = ST_SQR;
					end
				end
			end
			ST_MUL: begin
				if (mm_done) begin
					acc_d = mm_product;
					if (e_rest == '0) begin
						state_d = ST_WAIT;
					end else begin
						mm_start = 1'b1;
						mm_a     = base_q;
						mm_b     = base_q;
						state_d  = ST_SQR;
					end
				end
			end
			ST_SQR: begin
				if (mm_done) begin
					base_d   = mm_product;
					e_d      = e_rest;
					mm_start = 1'b1;
					if (e_q[1]) begin
						mm_a    = acc_q;
						state_d = ST_MUL;
					end else begin
						state_d = ST_SQR;
					end
				end
			end
			ST_WAIT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold working values
	always_ff @(posedge clk) begin
		acc_q  <= acc_d;
		base_q <= base_d;
		e_q    <= e_d;
	end

	modexp_mulmod #(
		.WORD_BITS(WORD_BITS)
	) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start),
		.a      (mm_a),
		.b      (mm_b),
		.m      (mod_w),
		.done   (mm_done),
		.product(mm_product)
	);

	// Output register: a finished result waits here while the next transaction starts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_mod_valid_q <= 1'b0;
		end else if (out_load) begin
			power_mod_valid_q <= 1'b1;
		end else if (!power_mod_stall) begin
			power_mod_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			power_mod_q <= FIELD_W'(acc_q);
		end
	end

	assign power_mod_valid = power_mod_valid_q;
	assign power_mod       = power_mod_q;

	// Multiplier completions only arrive while a multiply is expected
	a_done_in_mult: assert property (@(posedge clk) disable iff (!arst_n)
		mm_done |-> (state_q == ST_REDUCE || state_q == ST_MUL || state_q == ST_SQR))
		else $error("multiplier completion outside a multiply state");

	// An accepted message always starts work
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		msg_accept |=> (state_q != ST_IDLE))
		else $error("accepted message left the sequencer idle");

	// A computed result is fully reduced
	a_result_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL && state_d == ST_WAIT) |=> (acc_q < mod_w))
		else $error("result not below the modulus");

	// The pending result holds while the output register is full
	a_wait_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAIT && $past(state_q == ST_WAIT)) |-> $stable(acc_q))
		else $error("pending result changed while waiting");

endmodule

// ----- src/modexp_mulmod.sv -----
`timescale 1ns / 1ps
// Bit-serial modular multiplier: product = a * b mod m, one bit of b per cycle.
// Standalone; instantiated by modular_exponentiation_core. Needs a < m; b may take any value.
module modexp_mulmod #(
	parameter int WORD_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WORD_BITS-1:0] a,
	input  logic [WORD_BITS-1:0] b,
	input  logic [WORD_BITS-1:0] m,
	output logic                 done,
	output logic [WORD_BITS-1:0] product
);
	localparam int CNT_W = $clog2(WORD_BITS);
	localparam int EXT_W = WORD_BITS + 2;

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [WORD_BITS-1:0] acc_q;
	logic [WORD_BITS-1:0] a_q;
	logic [WORD_BITS-1:0] b_q;
	logic [WORD_BITS-1:0] m_q;

	logic [EXT_W-1:0]     sum;
	logic [EXT_W-1:0]     m1;
	logic [EXT_W-1:0]     m2;
	logic [EXT_W-1:0]     red;
	logic                 last_step;

	// Double the accumulator, add a when the current bit of b is set, then
	// fold the sum (below 3m) back under m with one of two subtractions.
	always_comb begin
		sum = {1'b0, acc_q, 1'b0} + (b_q[WORD_BITS-1] ? {2'b00, a_q} : '0);
		m1  = {2'b00, m_q};
		m2  = {1'b0, m_q, 1'b0};
		if (sum >= m2) begin
			red = sum - m2;
		end else if (sum >= m1) begin
			red = sum - m1;
		end else begin
			red = sum;
		end
	end

	assign last_step = (cnt_q == CNT_W'(WORD_BITS - 1));

	// Control: count one step per bit of b, flag completion for one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last_step;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: load operands on start, shift b out most significant bit first.
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
			m_q   <= m;
		end else if (busy_q) begin
			acc_q <= red[WORD_BITS-1:0];
			b_q   <= {b_q[WORD_BITS-2:0], 1'b0};
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule
